// ===== design/orat_pkg.sv =====
package orat_pkg;

  localparam int DEFAULT_ENTRIES = 16;
  localparam int MAX_EVENTS      = 16;
  localparam int EV_CW           = $clog2(MAX_EVENTS + 1);
  localparam int EV_IW           = $clog2(MAX_EVENTS);

  localparam int ACTION_W    = 3;
  localparam int ADDR_W      = 32;
  localparam int TAG_W       = 16;
  localparam int SLOT_W      = 4;
  localparam int CNT_OUT_W   = 5;
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_REGISTER  = 3'd0,
    ACT_WRITE     = 3'd1,
    ACT_FORCE_ON  = 3'd2,
    ACT_FORCE_OFF = 3'd3,
    ACT_QUERY     = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_SLOT = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ORD,
    S_OCK,
    S_JSCAN,
    S_IRD,
    S_ICK,
    S_FRD,
    S_FCK,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             on;
  } event_t;

endpackage

// ===== design/orat_overlap.sv =====
module orat_overlap (
  input  logic [orat_pkg::ADDR_W-1:0] a_base,
  input  logic [orat_pkg::ADDR_W-1:0] a_end,
  input  logic [orat_pkg::ADDR_W-1:0] b_base,
  input  logic [orat_pkg::ADDR_W-1:0] b_end,
  output logic                        hit
);
  import orat_pkg::*;

  // ends are precomputed with wraparound
  assign hit = (a_base < b_end) && (a_end > b_base);

endmodule

// ===== design/overlay_region_activation_tracker.sv =====
// channel | dir | tdata (low bit up)                                  | tuser      | tlast
// in_     | in  | addr[31:0] length[63:32] tag[79:64] slot[83:80]     | action     | -
// out_    | out | event_tag[15:0] event_active[16] status[18:17]      | event_valid| last
//         |     | entry_active[19] active_count[24:20]                |            |
// register, query, bad slot or unknown action: the state goes straight to S_EMIT
// force activate or deactivate: S_FRD reads the region table, S_FCK updates, then S_EMIT
// write: S_ORD and S_OCK check regions until one turns on; for an overlapping region,
// S_JSCAN scans, S_IRD and S_ICK compare each active region; S_EMIT loads the results
// rst_n clears control, counts and active bits; table entries are undefined until registered
// in_tready is low from a transfer until its last result is loaded; out stalls only hold
// the result stage
module overlay_region_activation_tracker #(
  parameter int ENTRIES = orat_pkg::DEFAULT_ENTRIES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [orat_pkg::IN_TDATA_W-1:0]  in_tdata,   // addr, length, tag, slot
  input  logic [orat_pkg::ACTION_W-1:0]    in_tuser,   // action
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [orat_pkg::OUT_TDATA_W-1:0] out_tdata,  // event_tag, event_active, status,
                                                       // entry_active, active_count
  output logic                             out_tuser,  // event_valid
  output logic                             out_tlast
);
  import orat_pkg::*;

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CMP_W = CNT_W + SLOT_W;

  logic [ADDR_W-1:0] in_addr, in_len, in_end;
  logic [TAG_W-1:0]  in_tag;
  logic [SLOT_W-1:0] in_slot;
  logic              in_fire;
  logic              slot_ok;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  rcnt_r, rcnt_nxt;
  logic [CNT_W-1:0]  acnt_r, acnt_nxt;
  logic [ENTRIES-1:0] active_r, active_nxt;
  action_t           act_r, act_nxt;
  status_t           status_r, status_nxt;
  logic              qact_r, qact_nxt;
  logic [IDX_W-1:0]  slot_r, slot_nxt;
  logic [ADDR_W-1:0] wr_base_r, wr_base_nxt, wr_end_r, wr_end_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt, j_r, j_nxt;
  logic [ADDR_W-1:0] ib_r, ib_nxt, ie_r, ie_nxt;
  logic [TAG_W-1:0]  itag_r, itag_nxt;
  logic [EV_CW-1:0]  evn_r, evn_nxt, rd_r, rd_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_evv_r, out_evv_nxt;
  logic [TAG_W-1:0]  out_tag_r, out_tag_nxt;
  logic              out_on_r, out_on_nxt;
  status_t           out_status_r, out_status_nxt;
  logic              out_qact_r, out_qact_nxt;
  logic [CNT_OUT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic              out_last_r, out_last_nxt;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;

  logic [ADDR_W-1:0] base_mem [ENTRIES];
  logic [ADDR_W-1:0] end_mem  [ENTRIES];
  logic [TAG_W-1:0]  tag_mem  [ENTRIES];
  logic              mem_we;
  logic [IDX_W-1:0]  mem_ra;
  logic [ADDR_W-1:0] rd_base_r, rd_end_r;
  logic [TAG_W-1:0]  rd_tag_r;

  event_t            ev_buf [MAX_EVENTS];
  logic              ev_push, ev_we;
  event_t            ev_wdata, ev_rdata;

  logic [ADDR_W-1:0] cmp_base, cmp_end;
  logic              hit;
  logic              res_last;

  assign in_addr = in_tdata[ADDR_W-1:0];
  assign in_len  = in_tdata[2*ADDR_W-1:ADDR_W];
  assign in_tag  = in_tdata[2*ADDR_W+TAG_W-1:2*ADDR_W];
  assign in_slot = in_tdata[2*ADDR_W+TAG_W+SLOT_W-1:2*ADDR_W+TAG_W];
  assign in_end  = in_addr + in_len;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign slot_ok   = CMP_W'(in_slot) < CMP_W'(rcnt_r);

  assign cmp_base = (state_r == S_OCK) ? wr_base_r : ib_r;
  assign cmp_end  = (state_r == S_OCK) ? wr_end_r  : ie_r;

  orat_overlap u_overlap (
    .a_base (rd_base_r),
    .a_end  (rd_end_r),
    .b_base (cmp_base),
    .b_end  (cmp_end),
    .hit    (hit)
  );

  assign ev_rdata = ev_buf[rd_r[EV_IW-1:0]];
  assign res_last = (evn_r == '0) || ((rd_r + 1'b1) == evn_r);
  assign cnt_ext  = {CNT_OUT_W'(0), acnt_r};

  always_comb begin
    unique case (state_r)
      S_ORD:   mem_ra = i_r[IDX_W-1:0];
      S_IRD:   mem_ra = j_r[IDX_W-1:0];
      default: mem_ra = slot_r;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    rcnt_nxt       = rcnt_r;
    acnt_nxt       = acnt_r;
    active_nxt     = active_r;
    act_nxt        = act_r;
    status_nxt     = status_r;
    qact_nxt       = qact_r;
    slot_nxt       = slot_r;
    wr_base_nxt    = wr_base_r;
    wr_end_nxt     = wr_end_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    ib_nxt         = ib_r;
    ie_nxt         = ie_r;
    itag_nxt       = itag_r;
    evn_nxt        = evn_r;
    rd_nxt         = rd_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_evv_nxt    = out_evv_r;
    out_tag_nxt    = out_tag_r;
    out_on_nxt     = out_on_r;
    out_status_nxt = out_status_r;
    out_qact_nxt   = out_qact_r;
    out_cnt_nxt    = out_cnt_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    ev_push        = 1'b0;
    ev_wdata       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          act_nxt     = action_t'(in_tuser);
          status_nxt  = ST_OK;
          qact_nxt    = 1'b0;
          evn_nxt     = '0;
          rd_nxt      = '0;
          slot_nxt    = IDX_W'(in_slot);
          wr_base_nxt = in_addr;
          wr_end_nxt  = in_end;
          i_nxt       = '0;
          state_nxt   = S_EMIT;
          case (action_t'(in_tuser))
            ACT_REGISTER: begin
              if (rcnt_r == CNT_W'(ENTRIES)) begin
                status_nxt = ST_FULL;
              end else begin
                mem_we = 1'b1;
                active_nxt[rcnt_r[IDX_W-1:0]] = 1'b0;
                rcnt_nxt = rcnt_r + 1'b1;
              end
            end
            ACT_WRITE: begin
              if (rcnt_r != '0) begin
                state_nxt = S_ORD;
              end
            end
            ACT_FORCE_ON, ACT_FORCE_OFF, ACT_QUERY: begin
              if (!slot_ok) begin
                status_nxt = ST_NO_SLOT;
              end else if (action_t'(in_tuser) == ACT_QUERY) begin
                qact_nxt = active_r[IDX_W'(in_slot)];
              end else begin
                state_nxt = S_FRD;
              end
            end
            default: begin
              state_nxt = S_EMIT;
            end
          endcase
        end
      end
      S_FRD: begin
        state_nxt = S_FCK;
      end
      S_FCK: begin
        if (act_r == ACT_FORCE_ON && !active_r[slot_r]) begin
          active_nxt[slot_r] = 1'b1;
          acnt_nxt = acnt_r + 1'b1;
          ev_push  = 1'b1;
          ev_wdata = '{tag: rd_tag_r, on: 1'b1};
        end else if (act_r == ACT_FORCE_OFF && active_r[slot_r]) begin
          active_nxt[slot_r] = 1'b0;
          acnt_nxt = acnt_r - 1'b1;
          ev_push  = 1'b1;
          ev_wdata = '{tag: rd_tag_r, on: 1'b0};
        end
        state_nxt = S_EMIT;
      end
      S_ORD: begin
        state_nxt = S_OCK;
      end
      S_OCK: begin
        if (hit) begin
          ib_nxt    = rd_base_r;
          ie_nxt    = rd_end_r;
          itag_nxt  = rd_tag_r;
          j_nxt     = '0;
          state_nxt = S_JSCAN;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ((i_r + 1'b1) == rcnt_r) ? S_EMIT : S_ORD;
        end
      end
      S_JSCAN: begin
        if (j_r == rcnt_r) begin
          if (!active_r[i_r[IDX_W-1:0]]) begin
            active_nxt[i_r[IDX_W-1:0]] = 1'b1;
            acnt_nxt  = acnt_r + 1'b1;
            ev_push   = 1'b1;
            ev_wdata  = '{tag: itag_r, on: 1'b1};
            state_nxt = S_EMIT;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = ((i_r + 1'b1) == rcnt_r) ? S_EMIT : S_ORD;
          end
        end else if (j_r == i_r || !active_r[j_r[IDX_W-1:0]]) begin
          j_nxt = j_r + 1'b1;
        end else begin
          state_nxt = S_IRD;
        end
      end
      S_IRD: begin
        state_nxt = S_ICK;
      end
      S_ICK: begin
        if (hit) begin
          active_nxt[j_r[IDX_W-1:0]] = 1'b0;
          acnt_nxt = acnt_r - 1'b1;
          ev_push  = 1'b1;
          ev_wdata = '{tag: rd_tag_r, on: 1'b0};
        end
        j_nxt     = j_r + 1'b1;
        state_nxt = S_JSCAN;
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_evv_nxt    = (evn_r != '0);
          out_tag_nxt    = (evn_r != '0) ? ev_rdata.tag : '0;
          out_on_nxt     = (evn_r != '0) ? ev_rdata.on : 1'b0;
          out_status_nxt = status_r;
          out_qact_nxt   = qact_r;
          out_cnt_nxt    = cnt_ext[CNT_OUT_W-1:0];
          out_last_nxt   = res_last;
          rd_nxt         = rd_r + 1'b1;
          if (res_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    ev_we = ev_push && (evn_r < EV_CW'(MAX_EVENTS));
    if (ev_we) begin
      evn_nxt = evn_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rcnt_r      <= '0;
      acnt_r      <= '0;
      active_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rcnt_r      <= rcnt_nxt;
      acnt_r      <= acnt_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    status_r     <= status_nxt;
    qact_r       <= qact_nxt;
    slot_r       <= slot_nxt;
    wr_base_r    <= wr_base_nxt;
    wr_end_r     <= wr_end_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    ib_r         <= ib_nxt;
    ie_r         <= ie_nxt;
    itag_r       <= itag_nxt;
    evn_r        <= evn_nxt;
    rd_r         <= rd_nxt;
    out_evv_r    <= out_evv_nxt;
    out_tag_r    <= out_tag_nxt;
    out_on_r     <= out_on_nxt;
    out_status_r <= out_status_nxt;
    out_qact_r   <= out_qact_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_last_r   <= out_last_nxt;
  end

  // region table, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      base_mem[rcnt_r[IDX_W-1:0]] <= in_addr;
      end_mem[rcnt_r[IDX_W-1:0]]  <= in_end;
      tag_mem[rcnt_r[IDX_W-1:0]]  <= in_tag;
    end
    rd_base_r <= base_mem[mem_ra];
    rd_end_r  <= end_mem[mem_ra];
    rd_tag_r  <= tag_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (ev_we) begin
      ev_buf[evn_r[EV_IW-1:0]] <= ev_wdata;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_evv_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'b0, out_cnt_r, out_qact_r, out_status_r, out_on_r, out_tag_r};

endmodule

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import orat_pkg::*;

  localparam int N_SLOTS      = DEFAULT_ENTRIES;
  localparam int RANDOM_ITEMS = 330;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 2_000_000;

  localparam logic [2:0]  ACT_SPARE_LO  = 3'd5;
  localparam logic [2:0]  ACT_SPARE_MID = 3'd6;
  localparam logic [2:0]  ACT_SPARE_HI  = 3'd7;
  localparam logic [31:0] WIN_BASE      = 32'h8001_0000;

  typedef struct {
    logic [2:0]  code;
    logic [31:0] addr;
    logic [31:0] len;
    logic [15:0] tag;
    logic [3:0]  slot;
  } tracker_cmd_t;

  typedef struct {
    logic             ev_valid;
    logic [TAG_W-1:0] ev_tag;
    logic             ev_on;
    status_t          status;
    logic             entry_on;
    logic [4:0]       live_count;
    logic             last;
  } tracker_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [ACTION_W-1:0]    in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;

  overlay_region_activation_tracker u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // region table as the tracker should hold it
  logic [31:0]      tbl_base [N_SLOTS];
  logic [31:0]      tbl_size [N_SLOTS];
  logic [TAG_W-1:0] tbl_tag  [N_SLOTS];
  logic             tbl_on   [N_SLOTS];
  int               tbl_used;

  logic [TAG_W-1:0] ev_tag [MAX_EVENTS];
  logic             ev_on  [MAX_EVENTS];
  int               ev_n;

  tracker_cmd_t    cmds_waiting[$];
  tracker_result_t results_due[$];

  logic     in_xfer = 1'b0;
  int       idle_left = 0;
  int       burst_left = 0;
  int       pat_left = 0;
  logic [7:0] ready_pat = 8'hFF;
  int       mismatches = 0;
  int       cmds_taken = 0;
  int       results_seen = 0;
  int       changes_seen = 0;
  int       full_seen = 0;
  int       no_slot_seen = 0;
  longint   cycle_count = 0;

  initial begin
    for (int k = 0; k < N_SLOTS; k++) tbl_on[k] = 1'b0;
    tbl_used = 0;
  end

  function automatic bit spans_meet(input logic [31:0] a0, input logic [31:0] alen,
                                    input logic [31:0] b0, input logic [31:0] blen);
    logic [31:0] a1;
    logic [31:0] b1;
    a1 = a0 + alen;
    b1 = b0 + blen;
    return (a0 < b1) && (a1 > b0);
  endfunction

  task automatic flip_region(input int k, input logic on);
    tbl_on[k] = on;
    if (ev_n < MAX_EVENTS) begin
      ev_tag[ev_n] = tbl_tag[k];
      ev_on[ev_n]  = on;
      ev_n++;
    end
  endtask

  task automatic track_command(input logic [2:0] code, input logic [31:0] addr,
                               input logic [31:0] len, input logic [15:0] tag,
                               input logic [3:0] slot);
    status_t         st;
    logic            q_on;
    int              live;
    int              n;
    bit              walk_done;
    tracker_result_t r;
    st        = ST_OK;
    q_on      = 1'b0;
    ev_n      = 0;
    walk_done = 0;
    case (code)
      ACT_REGISTER: begin
        if (tbl_used >= N_SLOTS) begin
          st = ST_FULL;
        end else begin
          tbl_base[tbl_used] = addr;
          tbl_size[tbl_used] = len;
          tbl_tag[tbl_used]  = tag;
          tbl_on[tbl_used]   = 1'b0;
          tbl_used++;
        end
      end
      ACT_WRITE: begin
        for (int i = 0; i < tbl_used && !walk_done; i++) begin
          if (spans_meet(addr, len, tbl_base[i], tbl_size[i])) begin
            for (int j = 0; j < tbl_used; j++) begin
              if (j != i && tbl_on[j] &&
                  spans_meet(tbl_base[j], tbl_size[j], tbl_base[i], tbl_size[i]))
                flip_region(j, 1'b0);
            end
            if (!tbl_on[i]) begin
              flip_region(i, 1'b1);
              walk_done = 1;
            end
          end
        end
      end
      ACT_FORCE_ON, ACT_FORCE_OFF, ACT_QUERY: begin
        if (int'(slot) >= tbl_used) begin
          st = ST_NO_SLOT;
        end else if (code == ACT_FORCE_ON) begin
          if (!tbl_on[slot]) flip_region(int'(slot), 1'b1);
        end else if (code == ACT_FORCE_OFF) begin
          if (tbl_on[slot]) flip_region(int'(slot), 1'b0);
        end else begin
          q_on = tbl_on[slot];
        end
      end
      default: begin
      end
    endcase

    live = 0;
    for (int k = 0; k < tbl_used; k++) if (tbl_on[k]) live++;

    n = (ev_n > 0) ? ev_n : 1;
    for (int e = 0; e < n; e++) begin
      r.ev_valid   = (ev_n > 0);
      r.ev_tag     = (ev_n > 0) ? ev_tag[e] : '0;
      r.ev_on      = (ev_n > 0) ? ev_on[e] : 1'b0;
      r.status     = st;
      r.entry_on   = q_on;
      r.live_count = 5'(live);
      r.last       = (e == n - 1);
      results_due = {results_due, r};
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic queue_cmd(input logic [2:0] code, input logic [31:0] addr,
                           input logic [31:0] len, input logic [15:0] tag,
                           input logic [3:0] slot);
    tracker_cmd_t c;
    c.code = code;
    c.addr = addr;
    c.len  = len;
    c.tag  = tag;
    c.slot = slot;
    cmds_waiting = {cmds_waiting, c};
  endtask

  // input side: bursts with random gaps
  always @(negedge clk) begin : feed
    tracker_cmd_t c;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_xfer) begin
      if (idle_left > 0) begin
        idle_left--;
        in_tvalid <= 1'b0;
      end else if (cmds_waiting.size() != 0) begin
        c = cmds_waiting.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {4'd0, c.slot, c.tag, c.len, c.addr};
        in_tuser  <= c.code;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          idle_left  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result side: rotating ready pattern, replaced by a new random one when its countdown runs out
  always @(negedge clk) begin : sink
    if (pat_left == 0) begin
      pat_left  = 32;
      ready_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
    end
    pat_left--;
    out_tready <= ready_pat[0];
    ready_pat = {ready_pat[0], ready_pat[7:1]};
  end

  always @(posedge clk) begin : watch
    tracker_result_t want;
    in_xfer <= rst_n && in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (out_tuser) changes_seen++;
      if (status_t'(out_tdata[18:17]) == ST_FULL) full_seen++;
      if (status_t'(out_tdata[18:17]) == ST_NO_SLOT) no_slot_seen++;
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none actual tdata=%0h tuser=%b tlast=%b",
                 $time, out_tdata, out_tuser, out_tlast);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        check_field("event_valid", 32'(want.ev_valid), 32'(out_tuser));
        check_field("event_tag", 32'(want.ev_tag), 32'(out_tdata[15:0]));
        check_field("event_active", 32'(want.ev_on), 32'(out_tdata[16]));
        check_field("status", 32'(want.status), 32'(out_tdata[18:17]));
        check_field("entry_active", 32'(want.entry_on), 32'(out_tdata[19]));
        check_field("active_count", 32'(want.live_count), 32'(out_tdata[24:20]));
        check_field("last", 32'(want.last), 32'(out_tlast));
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      cmds_taken++;
      track_command(in_tuser, in_tdata[31:0], in_tdata[63:32], in_tdata[79:64],
                    in_tdata[83:80]);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run did not finish, %0d results still due", $time, results_due.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    int          regs_made;
    int          pick;
    logic [31:0] a;
    logic [31:0] l;

    // empty table
    queue_cmd(ACT_QUERY, 32'h0, 32'h0, 16'h0, 4'd0);
    queue_cmd(ACT_FORCE_ON, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 4'd15);
    queue_cmd(ACT_WRITE, 32'h0, 32'hFFFF_FFFF, 16'h0, 4'd0);
    queue_cmd(ACT_SPARE_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 4'd15);
    queue_cmd(ACT_SPARE_MID, 32'h0, 32'h0, 16'h0, 4'd0);
    queue_cmd(ACT_SPARE_HI, $urandom, $urandom, 16'($urandom), 4'($urandom));
    // edge-case regions: overlapping pair, wrapping end, empty, near-full length
    queue_cmd(ACT_REGISTER, 32'h0000_0000, 32'h0000_1000, 16'h0000, 4'd0);
    queue_cmd(ACT_REGISTER, 32'h0000_0800, 32'h0000_1000, 16'hFFFF, 4'd0);
    queue_cmd(ACT_REGISTER, 32'hFFFF_F000, 32'h0000_2000, 16'h1234, 4'd0);
    queue_cmd(ACT_REGISTER, 32'h0000_0800, 32'h0000_0000, 16'h00FF, 4'd0);
    queue_cmd(ACT_REGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFF00, 4'd0);
    queue_cmd(ACT_FORCE_ON, 32'h0, 32'h0, 16'h0, 4'd0);
    queue_cmd(ACT_FORCE_ON, 32'h0, 32'h0, 16'h0, 4'd0);
    queue_cmd(ACT_FORCE_ON, 32'h0, 32'h0, 16'h0, 4'd1);
    queue_cmd(ACT_QUERY, 32'h0, 32'h0, 16'h0, 4'd1);
    queue_cmd(ACT_QUERY, 32'h0, 32'h0, 16'h0, 4'd5);
    queue_cmd(ACT_WRITE, 32'h0000_0C00, 32'h0000_0010, 16'h0, 4'd0);
    queue_cmd(ACT_FORCE_OFF, 32'h0, 32'h0, 16'h0, 4'd1);
    queue_cmd(ACT_FORCE_OFF, 32'h0, 32'h0, 16'h0, 4'd1);
    queue_cmd(ACT_WRITE, 32'hFFFF_FFF0, 32'h0000_0020, 16'h0, 4'd0);
    queue_cmd(ACT_FORCE_ON, 32'h0, 32'h0, 16'h0, 4'd2);
    queue_cmd(ACT_FORCE_ON, 32'h0, 32'h0, 16'h0, 4'd3);
    queue_cmd(ACT_FORCE_ON, 32'h0, 32'h0, 16'h0, 4'd4);
    queue_cmd(ACT_WRITE, 32'h0, 32'h0, 16'h0, 4'd0);
    queue_cmd(ACT_WRITE, 32'h0000_0100, 32'hFFFF_FFFF, 16'h0, 4'd0);
    regs_made = 5;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < ((regs_made < N_SLOTS) ? 20 : 4)) begin
        if ($urandom_range(0, 4) != 0) begin
          a = WIN_BASE + $urandom_range(0, 'h3000);
          l = $urandom_range(1, 'h1800);
        end else begin
          a = $urandom;
          l = $urandom;
        end
        queue_cmd(ACT_REGISTER, a, l, 16'($urandom), 4'($urandom));
        regs_made++;
      end else if (pick < 50) begin
        if ($urandom_range(0, 3) != 0) begin
          a = WIN_BASE - 'h400 + $urandom_range(0, 'h4000);
          case ($urandom_range(0, 9))
            0:       l = 32'h0;
            1:       l = $urandom_range('h2000, 'h8000);
            default: l = $urandom_range(1, 'h600);
          endcase
        end else begin
          a = $urandom;
          l = $urandom;
        end
        queue_cmd(ACT_WRITE, a, l, 16'($urandom), 4'($urandom));
      end else if (pick < 70) begin
        queue_cmd(ACT_FORCE_ON, $urandom, $urandom, 16'($urandom), 4'($urandom));
      end else if (pick < 84) begin
        queue_cmd(ACT_FORCE_OFF, $urandom, $urandom, 16'($urandom), 4'($urandom));
      end else if (pick < 96) begin
        queue_cmd(ACT_QUERY, $urandom, $urandom, 16'($urandom), 4'($urandom));
      end else begin
        queue_cmd(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)), $urandom, $urandom,
                  16'($urandom), 4'($urandom));
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (cmds_waiting.size() != 0 || in_tvalid) @(negedge clk);
    while (results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d commands and %0d result transfers, %0d activation changes",
             cmds_taken, results_seen, changes_seen);
    $display("with %0d table-full and %0d unregistered-slot answers over %0d regions",
             full_seen, no_slot_seen, tbl_used);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
